FILE: hw/rtl/bptl_pkg.sv
// Shared types and constants for the truncated linear BP message block.
`default_nettype none
package bptl_pkg;

  localparam int MAX_LABELS_DEF = 16;
  localparam int VALUE_BITS_DEF = 24;

  localparam int IN_W      = 20;
  localparam int OUT_W     = 24;
  localparam int IDX_OUT_W = 4;
  localparam int LC_W      = 5;
  localparam int WGT_W     = 16;
  localparam int TD_W      = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LABEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_WGT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRUNC_DIST  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FWD,
    ST_BWD,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FWD,
    CELL_BWD,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [WGT_W-1:0] weight;
  } cell_ctl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bptl_cell.sv
// One label cell: holds a value, applies envelope steps and shifts toward label 0.
`default_nettype none
module bptl_cell #(
  parameter int VALUE_BITS = bptl_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire bptl_pkg::cell_ctl_t          ctl,
  input  wire logic signed [VALUE_BITS-1:0] load_val,
  input  wire logic signed [VALUE_BITS-1:0] left_val,
  input  wire logic signed [VALUE_BITS-1:0] right_val,
  output logic signed [VALUE_BITS-1:0]      value
);

  // room for a neighbour value plus the full weight
  localparam int EW = ((VALUE_BITS > bptl_pkg::WGT_W) ? VALUE_BITS : bptl_pkg::WGT_W) + 2;

  logic signed [VALUE_BITS-1:0] v_r, v_nxt;
  logic signed [EW-1:0]         w_ext, v_ext, nb_ext, cand;

  always_comb begin
    w_ext  = EW'(ctl.weight);
    v_ext  = EW'(v_r);
    nb_ext = (ctl.op == bptl_pkg::CELL_FWD) ? EW'(left_val)
                                             : EW'(right_val);
    cand   = nb_ext + w_ext;
    v_nxt  = v_r;
    case (ctl.op)
      bptl_pkg::CELL_LOAD:  v_nxt = load_val;
      bptl_pkg::CELL_FWD,
      bptl_pkg::CELL_BWD: begin
        if (cand < v_ext) v_nxt = cand[VALUE_BITS-1:0];
      end
      bptl_pkg::CELL_SHIFT: v_nxt = right_val;
      default:              v_nxt = v_r;
    endcase
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  assign value = v_r;

endmodule
`default_nettype wire

FILE: hw/rtl/bp_truncated_linear_message.sv
// Top level: label loading, envelope sequencing, clamp, normalise and output.
//
// One label is taken per start beat (busy stays low while loading). The beat
// that brings the last label starts the message: a forward pass and a backward
// pass run along the row of label cells, one cell per cycle, then n result
// beats leave one per cycle as the row shifts toward label 0. Results appear
// in the cycle after they are formed, on out_strobe, for one cycle each; the
// receiver cannot stall them. Configuration is taken at once.
`default_nettype none
module bp_truncated_linear_message #(
  parameter int MAX_LABELS = bptl_pkg::MAX_LABELS_DEF,
  parameter int VALUE_BITS = bptl_pkg::VALUE_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [bptl_pkg::IN_W-1:0]       in_msg_a,
  input  wire logic signed [bptl_pkg::IN_W-1:0]       in_msg_b,
  input  wire logic signed [bptl_pkg::IN_W-1:0]       in_msg_c,
  input  wire logic signed [bptl_pkg::IN_W-1:0]       in_unary_cost,
  output logic                                        out_strobe,
  output logic signed [bptl_pkg::OUT_W-1:0]           out_message_value,
  output logic [bptl_pkg::IDX_OUT_W-1:0]              out_label_index,
  output logic                                        out_last_label,
  input  wire logic                                   cfg_we,
  input  wire logic [bptl_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [bptl_pkg::CFG_DAT_W-1:0]         cfg_wdata
);

  localparam int IW  = $clog2(MAX_LABELS);
  localparam int CW  = $clog2(MAX_LABELS + 1);
  localparam int WW  = (CW > bptl_pkg::LC_W) ? CW : bptl_pkg::LC_W;
  localparam int SUM_W = bptl_pkg::IN_W + 2;
  localparam int LW  = VALUE_BITS + 23;
  localparam int TW  = VALUE_BITS + 23;
  localparam int DW  = VALUE_BITS + 9;
  localparam int OW  = bptl_pkg::OUT_W;
  localparam int XW  = bptl_pkg::IDX_OUT_W;
  localparam int PW  = bptl_pkg::WGT_W + bptl_pkg::TD_W;

  localparam logic signed [LW-1:0] SUM_HI = LW'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
  localparam logic signed [LW-1:0] SUM_LO = -SUM_HI - LW'(1);
  localparam logic signed [DW-1:0] OUT_HI = DW'((64'sd1 <<< (OW - 1)) - 64'sd1);
  localparam logic signed [DW-1:0] OUT_LO = -OUT_HI - DW'(1);

  // configuration
  logic [bptl_pkg::LC_W-1:0]  label_count_r;
  logic [bptl_pkg::WGT_W-1:0] weight_r;
  logic [bptl_pkg::TD_W-1:0]  trunc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_count_r <= bptl_pkg::LC_W'(16);
      weight_r      <= bptl_pkg::WGT_W'(256);
      trunc_r       <= bptl_pkg::TD_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bptl_pkg::CFG_LABEL_COUNT: label_count_r <= cfg_wdata[bptl_pkg::LC_W-1:0];
        bptl_pkg::CFG_SMOOTH_WGT:  weight_r      <= cfg_wdata[bptl_pkg::WGT_W-1:0];
        bptl_pkg::CFG_TRUNC_DIST:  trunc_r       <= cfg_wdata[bptl_pkg::TD_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  bptl_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    load_count_r, load_count_nxt;
  logic [CW-1:0]    n_r, n_nxt;
  logic [CW-1:0]    step_r, step_nxt;
  logic signed [VALUE_BITS-1:0] rmin_r, rmin_nxt;
  logic signed [TW-1:0]         tmin_r, tmin_nxt;
  logic signed [VALUE_BITS-1:0] first_r, first_nxt;

  logic                         accept;
  logic [WW-1:0]                lc_ext;
  logic [CW-1:0]                want, n_new;
  logic                         trigger;
  logic signed [SUM_W-1:0]      sum_raw;
  logic signed [LW-1:0]         sum_ext;
  logic signed [VALUE_BITS-1:0] sum_sat;
  logic [PW-1:0]                prod;

  logic signed [VALUE_BITS-1:0] cell_val [MAX_LABELS];
  logic signed [VALUE_BITS-1:0] head_clamped;
  logic signed [DW-1:0]         diff;
  logic signed [OW-1:0]         diff_sat;
  logic                         emit_last;

  assign accept = start && !busy;

  always_comb begin
    lc_ext = WW'(label_count_r);
    if (label_count_r == '0) want = CW'(1);
    else if (lc_ext > WW'(MAX_LABELS)) want = CW'(MAX_LABELS);
    else want = CW'(lc_ext);
    n_new   = load_count_r + CW'(1);
    trigger = accept && (n_new >= want);
  end

  always_comb begin
    sum_raw = SUM_W'(in_msg_a) + SUM_W'(in_msg_b) + SUM_W'(in_msg_c)
            + SUM_W'(in_unary_cost);
    sum_ext = LW'(sum_raw);
    if (sum_ext > SUM_HI) sum_sat = SUM_HI[VALUE_BITS-1:0];
    else if (sum_ext < SUM_LO) sum_sat = SUM_LO[VALUE_BITS-1:0];
    else sum_sat = sum_ext[VALUE_BITS-1:0];
  end

  assign prod = PW'(weight_r) * PW'(trunc_r);

  always_comb begin
    head_clamped = (TW'(cell_val[0]) > tmin_r) ? tmin_r[VALUE_BITS-1:0] : cell_val[0];
    diff = DW'(head_clamped) - DW'(first_r);
    if (diff > OUT_HI) diff_sat = OUT_HI[OW-1:0];
    else if (diff < OUT_LO) diff_sat = OUT_LO[OW-1:0];
    else diff_sat = diff[OW-1:0];
    emit_last = (step_r == n_r - CW'(1));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bptl_pkg::ST_IDLE: if (trigger) state_nxt = bptl_pkg::ST_FWD;
      bptl_pkg::ST_FWD:  if (step_r >= n_r) state_nxt = bptl_pkg::ST_BWD;
      bptl_pkg::ST_BWD:  if (step_r == '0) state_nxt = bptl_pkg::ST_EMIT;
      bptl_pkg::ST_EMIT: if (emit_last) state_nxt = bptl_pkg::ST_IDLE;
      default:           state_nxt = bptl_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    load_count_nxt = load_count_r;
    n_nxt          = n_r;
    step_nxt       = step_r;
    rmin_nxt       = rmin_r;
    tmin_nxt       = tmin_r;
    first_nxt      = first_r;
    unique case (state_r)
      bptl_pkg::ST_IDLE: begin
        if (accept) begin
          if (load_count_r == '0 || sum_sat < rmin_r) rmin_nxt = sum_sat;
          load_count_nxt = trigger ? '0 : n_new;
          n_nxt          = n_new;
          step_nxt       = CW'(1);
        end
      end
      bptl_pkg::ST_FWD: begin
        tmin_nxt = TW'(rmin_r) + TW'(prod);
        if (step_r >= n_r) step_nxt = n_r - CW'(1);
        else step_nxt = step_r + CW'(1);
      end
      bptl_pkg::ST_BWD: begin
        if (step_r == '0) first_nxt = head_clamped;
        else step_nxt = step_r - CW'(1);
      end
      bptl_pkg::ST_EMIT: step_nxt = step_r + CW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bptl_pkg::ST_IDLE;
      load_count_r <= '0;
      rmin_r       <= '0;
      n_r          <= '0;
      step_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      load_count_r <= load_count_nxt;
      rmin_r       <= rmin_nxt;
      n_r          <= n_nxt;
      step_r       <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tmin_r  <= tmin_nxt;
    first_r <= first_nxt;
  end

  // outputs
  logic            out_strobe_r, out_strobe_nxt;
  logic signed [OW-1:0] out_value_r, out_value_nxt;
  logic [XW-1:0]   out_index_r, out_index_nxt;
  logic            out_last_r, out_last_nxt;

  always_comb begin
    busy           = (state_r != bptl_pkg::ST_IDLE);
    out_strobe_nxt = (state_r == bptl_pkg::ST_EMIT);
    out_value_nxt  = diff_sat;
    out_index_nxt  = XW'(step_r);
    out_last_nxt   = (state_r == bptl_pkg::ST_EMIT) && emit_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_index_r <= out_index_nxt;
  end

  assign out_strobe        = out_strobe_r;
  assign out_message_value = out_value_r;
  assign out_label_index   = out_index_r;
  assign out_last_label    = out_last_r;

  // row of label cells
  for (genvar i = 0; i < MAX_LABELS; i++) begin : g_cell
    bptl_pkg::cell_ctl_t          ctl;
    logic signed [VALUE_BITS-1:0] left_v, right_v;

    always_comb begin
      ctl.weight = weight_r;
      ctl.op     = bptl_pkg::CELL_HOLD;
      unique case (state_r)
        bptl_pkg::ST_IDLE:
          if (accept && load_count_r[IW-1:0] == IW'(i)) ctl.op = bptl_pkg::CELL_LOAD;
        bptl_pkg::ST_FWD:
          if (i > 0 && step_r < n_r && step_r == CW'(i)) ctl.op = bptl_pkg::CELL_FWD;
        bptl_pkg::ST_BWD:
          if (step_r != '0 && step_r == CW'(i + 1)) ctl.op = bptl_pkg::CELL_BWD;
        bptl_pkg::ST_EMIT: ctl.op = bptl_pkg::CELL_SHIFT;
        default: ;
      endcase
    end

    if (i == 0) begin : g_left_edge
      assign left_v = '0;
    end else begin : g_left
      assign left_v = cell_val[i-1];
    end
    if (i == MAX_LABELS - 1) begin : g_right_edge
      assign right_v = '0;
    end else begin : g_right
      assign right_v = cell_val[i+1];
    end

    bptl_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load_val  (sum_sat),
      .left_val  (left_v),
      .right_val (right_v),
      .value     (cell_val[i])
    );
  end

  // checks
  a_strobe_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == bptl_pkg::ST_EMIT))
    else $error("result beat without emission");

  a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bptl_pkg::ST_EMIT && emit_last) |=> state_r == bptl_pkg::ST_IDLE)
    else $error("emission did not end after last label");

  a_last_then_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_label |-> out_strobe ##1 !out_strobe)
    else $error("beat after last label");

  a_trigger_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
    trigger |=> (state_r == bptl_pkg::ST_FWD && load_count_r == '0))
    else $error("message did not start");

endmodule
`default_nettype wire
